@@ rtl/core/bsli_pkg.sv @@
// ----------------------------------------------------------------------------
// bsli_pkg: shared types and constants of the battery status LED indicator
// Holds the configuration, input item and tick state types, the register
// indexes and the fixed PWM levels used by the core and its tick logic.
// ----------------------------------------------------------------------------
`default_nettype none

package bsli_pkg;

    // Full-scale PWM compare value and the fixed mixing levels.
    localparam logic [15:0] PWM_FULL_SCALE = 16'hFFFF;
    localparam logic [15:0] YELLOW_RED_LEVEL = 16'h7000;
    localparam logic [15:0] YELLOW_WHITE_LEVEL = 16'h1000;
    localparam logic [15:0] LEVEL_OFF = 16'h0000;

    // Charge input saturates at this percentage.
    localparam logic [6:0] PCT_MAX = 7'd100;

    // Battery current at or above this value counts as charging.
    localparam logic signed [15:0] CURRENT_CHARGE_MIN = -16'sd1;

    // Configuration port geometry.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 15;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_FADE_STEP = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CYCLE_STEP = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLINK_HALF = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_GREEN_ABOVE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_YELLOW_ABOVE = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOW_ABOVE = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLEEP_ABOVE = 3'd6;

    // LED channel positions in the level vector.
    localparam int LED_RED = 0;
    localparam int LED_GREEN = 1;
    localparam int LED_BLUE = 2;
    localparam int LED_WHITE = 3;

    // Calibration crossfade phase.
    typedef enum logic [1:0] {
        PHASE_RED_GREEN  = 2'd0,
        PHASE_GREEN_BLUE = 2'd1,
        PHASE_BLUE_RED   = 2'd2
    } cycle_phase_t;

    typedef struct packed {
        logic [14:0] fade_step;
        logic [14:0] cycle_step;
        logic [8:0]  blink_half_ticks;
        logic [6:0]  green_above;
        logic [6:0]  yellow_above;
        logic [6:0]  low_above;
        logic [6:0]  sleep_above;
    } cfg_t;

    typedef struct packed {
        logic [6:0]         charge_percent;
        logic signed [15:0] battery_current;
        logic               calibrate;
    } item_t;

    typedef struct packed {
        logic signed [16:0] fade_level;
        logic               fade_rising;
        logic signed [9:0]  blink_count;
        logic               blink_lit;
        logic [16:0]        cycle_level;
        cycle_phase_t       cycle_phase;
        logic [3:0][15:0]   led_levels;
    } state_t;

endpackage

`default_nettype wire

@@ rtl/core/battery_status_led_indicator_core.sv @@
// Path: input register, then result register; out_valid rises when the held item moves
// into the result register, and the result transfer completes when out_ready is high.
// Throughput: one item per cycle unless the result stalls; tick state loops via bsli_tick.
// A stalled result register holds the input stage until the result transfer completes.
// Reset: configuration returns to its defaults, all tick state and LED levels clear to zero.
// ----------------------------------------------------------------------------
// battery_status_led_indicator_core: battery status LED indicator
// Takes one tick item per transfer (charge, current, calibrate) and returns the
// four RGBW PWM levels and the sleep flag for that tick.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_status_led_indicator_core (
    input  logic                                 clk,
    input  logic                                 rst_n,

    // Configuration write port.
    input  logic                                 cfg_write,
    input  logic [bsli_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bsli_pkg::CFG_DATA_W-1:0]      cfg_data,

    // Tick input channel.
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [6:0]                           charge_percent,
    input  logic signed [15:0]                   battery_current,
    input  logic                                 calibrate,

    // Result channel.
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [15:0]                          red_level,
    output logic [15:0]                          green_level,
    output logic [15:0]                          blue_level,
    output logic [15:0]                          white_level,
    output logic                                 sleep_flag
);
    import bsli_pkg::*;

    // Configuration registers: the user writes only while the core is idle, unchecked.
    cfg_t   cfg_reg;
    cfg_t   cfg_next;

    // Input stage: holds one accepted tick item.
    item_t  item_reg;
    logic   item_valid_reg;
    logic   item_valid_next;

    // Tick state. The LED levels in it double as the result payload, since
    // the result of a tick is exactly the stored level set after that tick.
    state_t state_reg;
    state_t state_next;
    logic   sleep_reg;
    logic   sleep_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    logic   advance;
    logic   in_fire;
    item_t  item_in;

    // The input stage moves into the result register whenever the result
    // register is empty or its current transfer completes in this cycle.
    assign advance = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || advance;
    assign in_fire = in_valid && in_ready;

    assign item_in.charge_percent = charge_percent;
    assign item_in.battery_current = battery_current;
    assign item_in.calibrate = calibrate;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_FADE_STEP:    cfg_next.fade_step = cfg_data[14:0];
                CFG_CYCLE_STEP:   cfg_next.cycle_step = cfg_data[14:0];
                CFG_BLINK_HALF:   cfg_next.blink_half_ticks = cfg_data[8:0];
                CFG_GREEN_ABOVE:  cfg_next.green_above = cfg_data[6:0];
                CFG_YELLOW_ABOVE: cfg_next.yellow_above = cfg_data[6:0];
                CFG_LOW_ABOVE:    cfg_next.low_above = cfg_data[6:0];
                CFG_SLEEP_ABOVE:  cfg_next.sleep_above = cfg_data[6:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    // All the per-tick decisions live in the tick logic; here it only sees
    // the held item, the configuration and the current state.
    state_t tick_state;
    logic   tick_sleep;

    bsli_tick u_tick (
        .cfg       (cfg_reg),
        .item      (item_reg),
        .state_cur (state_reg),
        .state_nxt (tick_state),
        .sleep     (tick_sleep)
    );

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (in_fire)
        begin
            item_valid_next = 1'b1;
        end
        else if (advance)
        begin
            item_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        sleep_next = sleep_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            state_next = tick_state;
            sleep_next = tick_sleep;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fade_step <= 15'd100;
            cfg_reg.cycle_step <= 15'd100;
            cfg_reg.blink_half_ticks <= 9'd200;
            cfg_reg.green_above <= 7'd65;
            cfg_reg.yellow_above <= 7'd25;
            cfg_reg.low_above <= 7'd10;
            cfg_reg.sleep_above <= 7'd5;
            state_reg <= '0;
            sleep_reg <= 1'b0;
            item_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
            state_reg <= state_next;
            sleep_reg <= sleep_next;
            item_valid_reg <= item_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The input payload register needs no reset; its valid bit guards it.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg <= item_in;
        end
    end

    assign out_valid = out_valid_reg;
    assign red_level = state_reg.led_levels[LED_RED];
    assign green_level = state_reg.led_levels[LED_GREEN];
    assign blue_level = state_reg.led_levels[LED_BLUE];
    assign white_level = state_reg.led_levels[LED_WHITE];
    assign sleep_flag = sleep_reg;

endmodule

`default_nettype wire

@@ rtl/core/bsli_tick.sv @@
// ----------------------------------------------------------------------------
// bsli_tick: combinational tick logic of the battery status LED indicator
// Computes the next indicator state and the sleep flag for one input item.
// ----------------------------------------------------------------------------
`default_nettype none

module bsli_tick (
    input  bsli_pkg::cfg_t   cfg,
    input  bsli_pkg::item_t  item,
    input  bsli_pkg::state_t state_cur,
    output bsli_pkg::state_t state_nxt,
    output logic             sleep
);
    import bsli_pkg::*;

    localparam logic signed [17:0] FULL_SCALE_S = $signed({2'b00, PWM_FULL_SCALE});

    function automatic logic [15:0] clamp_level(input logic signed [17:0] v);
        logic [15:0] r;
        if (v < 18'sd0)
        begin
            r = LEVEL_OFF;
        end
        else if (v > FULL_SCALE_S)
        begin
            r = PWM_FULL_SCALE;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

    logic [6:0]         pct;
    logic               charging;
    logic               band_green;
    logic               band_yellow;

    logic signed [17:0] fade_cur;
    logic signed [17:0] fade_step_s;
    logic signed [17:0] fade_sum;
    logic               fade_up;
    logic [15:0]        fade_shown;

    logic signed [17:0] cyc_cur;
    logic signed [17:0] cyc_step_s;
    logic signed [17:0] cyc_sum;
    logic               cyc_wrap;
    logic [15:0]        cyc_up;
    logic [15:0]        cyc_down;
    logic [3:0][15:0]   cyc_leds;
    logic               cyc_write;
    cycle_phase_t       phase_adv;

    logic               blink_on;
    logic [3:0][15:0]   fade_leds;
    logic [3:0][15:0]   solid_leds;

    assign pct = (item.charge_percent > PCT_MAX) ? PCT_MAX : item.charge_percent;
    assign charging = (item.battery_current >= CURRENT_CHARGE_MIN);
    assign band_green = (pct > cfg.green_above);
    assign band_yellow = (pct > cfg.yellow_above);

    // Breathing fade: the direction turns at the top and bottom, then the level moves.
    assign fade_cur = {state_cur.fade_level[16], state_cur.fade_level};
    assign fade_step_s = $signed({3'b000, cfg.fade_step});
    assign fade_up = (fade_cur >= FULL_SCALE_S - fade_step_s) ? 1'b0 :
                     (fade_cur <= 18'sd0) ? 1'b1 : state_cur.fade_rising;
    assign fade_sum = fade_up ? (fade_cur + fade_step_s) : (fade_cur - fade_step_s);
    assign fade_shown = clamp_level(FULL_SCALE_S - fade_sum);

    // Calibration crossfade between two colors per phase.
    assign cyc_cur = $signed({1'b0, state_cur.cycle_level});
    assign cyc_step_s = $signed({3'b000, cfg.cycle_step});
    assign cyc_sum = cyc_cur + cyc_step_s;
    assign cyc_wrap = (cyc_sum >= FULL_SCALE_S - cyc_step_s);
    assign cyc_up = clamp_level(cyc_cur);
    assign cyc_down = clamp_level(FULL_SCALE_S - cyc_cur);

    always_comb
    begin
        cyc_leds = '0;
        cyc_write = 1'b1;
        case (state_cur.cycle_phase)
            PHASE_RED_GREEN:
            begin
                cyc_leds[LED_RED] = cyc_down;
                cyc_leds[LED_GREEN] = cyc_up;
                phase_adv = PHASE_GREEN_BLUE;
            end
            PHASE_GREEN_BLUE:
            begin
                cyc_leds[LED_GREEN] = cyc_down;
                cyc_leds[LED_BLUE] = cyc_up;
                phase_adv = PHASE_BLUE_RED;
            end
            PHASE_BLUE_RED:
            begin
                cyc_leds[LED_RED] = cyc_up;
                cyc_leds[LED_BLUE] = cyc_down;
                phase_adv = PHASE_RED_GREEN;
            end
            default:
            begin
                // An unused phase code writes nothing and wraps.
                cyc_write = 1'b0;
                phase_adv = PHASE_RED_GREEN;
            end
        endcase
    end

    always_comb
    begin
        fade_leds = '0;
        solid_leds = '0;
        if (band_green)
        begin
            fade_leds[LED_GREEN] = fade_shown;
            solid_leds[LED_GREEN] = PWM_FULL_SCALE;
        end
        else if (band_yellow)
        begin
            fade_leds[LED_RED] = fade_shown;
            fade_leds[LED_GREEN] = fade_shown;
            solid_leds[LED_RED] = YELLOW_RED_LEVEL;
            solid_leds[LED_GREEN] = PWM_FULL_SCALE;
            solid_leds[LED_WHITE] = YELLOW_WHITE_LEVEL;
        end
        else
        begin
            fade_leds[LED_RED] = fade_shown;
            solid_leds[LED_RED] = PWM_FULL_SCALE;
        end
    end

    assign blink_on = (state_cur.blink_count >= $signed({1'b0, cfg.blink_half_ticks})) ? 1'b0 :
                      (state_cur.blink_count <= 10'sd0) ? 1'b1 : state_cur.blink_lit;

    always_comb
    begin
        state_nxt = state_cur;
        sleep = 1'b0;
        if (item.calibrate)
        begin
            if (cyc_write)
            begin
                state_nxt.led_levels = cyc_leds;
            end
            if (cyc_wrap)
            begin
                state_nxt.cycle_level = '0;
                state_nxt.cycle_phase = phase_adv;
            end
            else
            begin
                state_nxt.cycle_level = cyc_sum[16:0];
            end
        end
        if (pct > cfg.low_above)
        begin
            if (charging)
            begin
                state_nxt.fade_rising = fade_up;
                state_nxt.fade_level = fade_sum[16:0];
                state_nxt.led_levels = fade_leds;
            end
            else
            begin
                state_nxt.led_levels = solid_leds;
            end
        end
        else if (pct > cfg.sleep_above)
        begin
            state_nxt.blink_lit = blink_on;
            state_nxt.led_levels = '0;
            if (blink_on)
            begin
                state_nxt.led_levels[LED_RED] = PWM_FULL_SCALE;
                state_nxt.blink_count = state_cur.blink_count + 10'sd1;
            end
            else
            begin
                state_nxt.blink_count = state_cur.blink_count - 10'sd1;
            end
        end
        else
        begin
            sleep = 1'b1;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/bsli_checker.sv @@
// ----------------------------------------------------------------------------
// bsli_port_checker: port-level checks of the battery status LED indicator core
// Tracks transfers on both channels and checks ordering, capacity and stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module bsli_port_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] red_level,
    input logic [15:0] green_level,
    input logic [15:0] blue_level,
    input logic [15:0] white_level,
    input logic        sleep_flag
);
    // Items accepted whose result transfer has not yet completed.
    logic [1:0] pending_reg;
    logic [1:0] pending_next;

    always_comb
    begin
        pending_next = pending_reg + {1'b0, in_valid && in_ready} - {1'b0, out_valid && out_ready};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // A stalled result keeps its levels and flag.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red_level) && $stable(green_level)
            && $stable(blue_level) && $stable(white_level) && $stable(sleep_flag))
        else $error("result changed while stalled");

    // A result is only offered for an item that was taken in.
    a_out_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 2'd0)
        else $error("result without an accepted item");

    // The core holds at most two items: one in the input stage, one in the result register.
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("more items in flight than stages");

    // With the result side empty, the input side never stalls.
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with an empty result register");

endmodule

bind battery_status_led_indicator_core bsli_port_checker u_bsli_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .red_level   (red_level),
    .green_level (green_level),
    .blue_level  (blue_level),
    .white_level (white_level),
    .sleep_flag  (sleep_flag)
);

`default_nettype wire

@@ sim/bsli_checker.sv @@
// ----------------------------------------------------------------------------
// bsli_checker: result predictor and comparator for the LED indicator core
// Watches the configuration port and both channels, keeps a private copy of
// the tick state, and compares every result transfer against the oldest
// predicted level set.
// ----------------------------------------------------------------------------
module bsli_checker
    import bsli_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic [6:0]             charge_percent,
    input  logic signed [15:0]     battery_current,
    input  logic                   calibrate,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic [15:0]            red_level,
    input  logic [15:0]            green_level,
    input  logic [15:0]            blue_level,
    input  logic [15:0]            white_level,
    input  logic                   sleep_flag,
    output int                     fail_count,
    output int                     levels_pending
);

    localparam int FULL = int'(PWM_FULL_SCALE);

    typedef struct {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] white;
        logic        sleep;
    } led_result_t;

    cfg_t         cfg;
    int           fade_level;
    bit           fade_rising;
    int           blink_count;
    bit           blink_lit;
    int           cycle_level;
    cycle_phase_t cycle_phase;
    logic [15:0]  leds [4];
    led_result_t  expected_levels [$];

    function automatic logic [15:0] clamp_level(input int v);
        if (v < 0)
            return LEVEL_OFF;
        if (v > FULL)
            return PWM_FULL_SCALE;
        return v[15:0];
    endfunction

    task automatic drive_leds(input int r, input int g, input int b, input int w);
        leds[LED_RED]   = clamp_level(r);
        leds[LED_GREEN] = clamp_level(g);
        leds[LED_BLUE]  = clamp_level(b);
        leds[LED_WHITE] = clamp_level(w);
    endtask

    task automatic load_defaults();
        cfg.fade_step        = 15'd100;
        cfg.cycle_step       = 15'd100;
        cfg.blink_half_ticks = 9'd200;
        cfg.green_above      = 7'd65;
        cfg.yellow_above     = 7'd25;
        cfg.low_above        = 7'd10;
        cfg.sleep_above      = 7'd5;
        fade_level  = 0;
        fade_rising = 1'b0;
        blink_count = 0;
        blink_lit   = 1'b0;
        cycle_level = 0;
        cycle_phase = PHASE_RED_GREEN;
        drive_leds(0, 0, 0, 0);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_FADE_STEP:    cfg.fade_step        = value[14:0];
            CFG_CYCLE_STEP:   cfg.cycle_step       = value[14:0];
            CFG_BLINK_HALF:   cfg.blink_half_ticks = value[8:0];
            CFG_GREEN_ABOVE:  cfg.green_above      = value[6:0];
            CFG_YELLOW_ABOVE: cfg.yellow_above     = value[6:0];
            CFG_LOW_ABOVE:    cfg.low_above        = value[6:0];
            CFG_SLEEP_ABOVE:  cfg.sleep_above      = value[6:0];
            default: ;
        endcase
    endtask

    task automatic step_crossfade();
        int c;
        int s;
        c = cycle_level;
        s = int'(cfg.cycle_step);
        case (cycle_phase)
            PHASE_RED_GREEN:  drive_leds(FULL - c, c, 0, 0);
            PHASE_GREEN_BLUE: drive_leds(0, FULL - c, c, 0);
            PHASE_BLUE_RED:   drive_leds(c, 0, FULL - c, 0);
            default: ;
        endcase
        c += s;
        if (c >= FULL - s) begin
            c = 0;
            if (cycle_phase >= PHASE_BLUE_RED)
                cycle_phase = PHASE_RED_GREEN;
            else
                cycle_phase = cycle_phase_t'(cycle_phase + 2'd1);
        end
        cycle_level = c;
    endtask

    task automatic step_breathing(input logic [6:0] pct);
        int s;
        int v;
        s = int'(cfg.fade_step);
        if (fade_level >= FULL - s)
            fade_rising = 1'b0;
        else if (fade_level <= 0)
            fade_rising = 1'b1;
        fade_level = fade_rising ? fade_level + s : fade_level - s;
        v = FULL - fade_level;
        if (pct > cfg.green_above)
            drive_leds(0, v, 0, 0);
        else if (pct > cfg.yellow_above)
            drive_leds(v, v, 0, 0);
        else
            drive_leds(v, 0, 0, 0);
    endtask

    task automatic step_solid(input logic [6:0] pct);
        if (pct > cfg.green_above)
            drive_leds(0, FULL, 0, 0);
        else if (pct > cfg.yellow_above)
            drive_leds(int'(YELLOW_RED_LEVEL), FULL, 0, int'(YELLOW_WHITE_LEVEL));
        else
            drive_leds(FULL, 0, 0, 0);
    endtask

    task automatic step_blink();
        if (blink_count >= int'(cfg.blink_half_ticks))
            blink_lit = 1'b0;
        else if (blink_count <= 0)
            blink_lit = 1'b1;
        if (blink_lit) begin
            drive_leds(FULL, 0, 0, 0);
            blink_count++;
        end
        else begin
            drive_leds(0, 0, 0, 0);
            blink_count--;
        end
    endtask

    task automatic predict_tick(input logic [6:0] pct_in, input logic signed [15:0] cur,
                                input logic cal, output led_result_t res);
        logic [6:0] pct;
        logic       asleep;
        pct = (pct_in > PCT_MAX) ? PCT_MAX : pct_in;
        asleep = 1'b0;
        if (cal)
            step_crossfade();
        if (pct > cfg.low_above) begin
            if (cur >= CURRENT_CHARGE_MIN)
                step_breathing(pct);
            else
                step_solid(pct);
        end
        else if (pct > cfg.sleep_above)
            step_blink();
        else
            asleep = 1'b1;
        res.red   = leds[LED_RED];
        res.green = leds[LED_GREEN];
        res.blue  = leds[LED_BLUE];
        res.white = leds[LED_WHITE];
        res.sleep = asleep;
    endtask

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
        end
    endtask

    // Results are checked before the same-edge input is predicted, so an
    // unexpected result can never be matched against a brand new prediction.
    always @(posedge clk or negedge rst_n) begin : monitor
        led_result_t want;
        led_result_t fresh;
        if (!rst_n) begin
            load_defaults();
            expected_levels.delete();
            fail_count = 0;
            levels_pending <= 0;
        end
        else begin
            if (out_valid && out_ready) begin
                if (expected_levels.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, actual red 0x%0h",
                             $time, red_level);
                end
                else begin
                    want = expected_levels.pop_front();
                    check_field("red_level", want.red, red_level);
                    check_field("green_level", want.green, green_level);
                    check_field("blue_level", want.blue, blue_level);
                    check_field("white_level", want.white, white_level);
                    check_field("sleep_flag", want.sleep, sleep_flag);
                end
            end
            if (cfg_write)
                write_register(cfg_index, cfg_data);
            if (in_valid && in_ready) begin
                predict_tick(charge_percent, battery_current, calibrate, fresh);
                expected_levels.push_back(fresh);
            end
            levels_pending <= expected_levels.size();
        end
    end

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench for the battery status LED indicator core
// Drives directed and random tick transfers through several register
// settings and three idling patterns; a separate checker predicts and
// compares every result transfer and reports the failure count.
// ----------------------------------------------------------------------------
module tb_top;
    import bsli_pkg::*;

    // Index 7 is not a register; a write to it must leave the block unchanged.
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 3'd7;
    localparam int SEGMENTS = 6;
    localparam int TICKS_PER_SEGMENT = 315;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic [6:0]             charge_percent;
    logic signed [15:0]     battery_current;
    logic                   calibrate;
    logic                   out_valid;
    logic                   out_ready;
    logic [15:0]            red_level;
    logic [15:0]            green_level;
    logic [15:0]            blue_level;
    logic [15:0]            white_level;
    logic                   sleep_flag;

    int fail_count;
    int levels_pending;

    // Percent chance per cycle that the sender or the receiver holds off.
    int in_idle_pct = 14;
    int out_idle_pct = 74;

    battery_status_led_indicator_core uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .charge_percent  (charge_percent),
        .battery_current (battery_current),
        .calibrate       (calibrate),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .red_level       (red_level),
        .green_level     (green_level),
        .blue_level      (blue_level),
        .white_level     (white_level),
        .sleep_flag      (sleep_flag)
    );

    bsli_checker level_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .charge_percent  (charge_percent),
        .battery_current (battery_current),
        .calibrate       (calibrate),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .red_level       (red_level),
        .green_level     (green_level),
        .blue_level      (blue_level),
        .white_level     (white_level),
        .sleep_flag      (sleep_flag),
        .fail_count      (fail_count),
        .levels_pending  (levels_pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The receiver decides afresh every cycle whether it takes a result.
    initial begin
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            out_ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    // Hard limit on the run, far beyond the slowest legal completion.
    initial begin
        #3000000;
        $display("Verification failed");
        $finish;
    end

    // Offers one tick and returns at the edge where its transfer happens.
    // Valid is only lowered while the sender chooses to idle, so a tick that
    // follows straight on keeps valid high with a single assignment.
    task automatic send_tick(input logic [6:0] pct, input logic signed [15:0] cur,
                             input logic cal);
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        charge_percent  <= pct;
        battery_current <= cur;
        calibrate       <= cal;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // Waits until every predicted result has been taken, then lets the two
    // pipeline stages settle before the registers may change.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (levels_pending != 0);
        repeat (2) @(posedge clk);
    endtask

    // Register settings, one per random segment. Between them they reach
    // the widest and narrowest steps, zero steps and a zero half period,
    // thresholds out of order, masking of wide write data, and a write to
    // the unused index.
    task automatic apply_setting(input int k);
        case (k)
            0: begin
                write_reg(CFG_FADE_STEP, 15'd4000);
                write_reg(CFG_CYCLE_STEP, 15'd3000);
                write_reg(CFG_BLINK_HALF, 15'd7);
            end
            1: begin
                write_reg(CFG_FADE_STEP, 15'd32767);
                write_reg(CFG_CYCLE_STEP, 15'd32767);
                write_reg(CFG_BLINK_HALF, 15'd1);
                write_reg(CFG_GREEN_ABOVE, 15'd100);
                write_reg(CFG_YELLOW_ABOVE, 15'd0);
                write_reg(CFG_LOW_ABOVE, 15'd0);
                write_reg(CFG_SLEEP_ABOVE, 15'd0);
            end
            2: begin
                // Yellow sits above green, and sleep above low, so the
                // fallback to the red band and the missing blink band show.
                write_reg(CFG_FADE_STEP, 15'd1);
                write_reg(CFG_CYCLE_STEP, 15'd1);
                write_reg(CFG_BLINK_HALF, 15'd511);
                write_reg(CFG_GREEN_ABOVE, 15'd40);
                write_reg(CFG_YELLOW_ABOVE, 15'd70);
                write_reg(CFG_LOW_ABOVE, 15'd20);
                write_reg(CFG_SLEEP_ABOVE, 15'd60);
            end
            3: begin
                // The half period write only keeps its low nine bits, which
                // are zero here; green ends at 127 and is never reached.
                write_reg(CFG_FADE_STEP, 15'd0);
                write_reg(CFG_CYCLE_STEP, 15'd0);
                write_reg(CFG_BLINK_HALF, 15'h7E00);
                write_reg(CFG_GREEN_ABOVE, 15'h7FFF);
                write_reg(CFG_YELLOW_ABOVE, 15'd80);
                write_reg(CFG_LOW_ABOVE, 15'd40);
                write_reg(CFG_SLEEP_ABOVE, 15'd20);
                write_reg(CFG_UNUSED_INDEX, 15'h7FFF);
            end
            4: begin
                write_reg(CFG_FADE_STEP, 15'd2500);
                write_reg(CFG_CYCLE_STEP, 15'd7000);
                write_reg(CFG_BLINK_HALF, 15'd3);
                write_reg(CFG_GREEN_ABOVE, 15'd65);
                write_reg(CFG_YELLOW_ABOVE, 15'd25);
                write_reg(CFG_LOW_ABOVE, 15'd10);
                write_reg(CFG_SLEEP_ABOVE, 15'd5);
            end
            default: begin
                write_reg(CFG_FADE_STEP, 15'd123);
                write_reg(CFG_CYCLE_STEP, 15'd20000);
                write_reg(CFG_BLINK_HALF, 15'd40);
                write_reg(CFG_GREEN_ABOVE, 15'd90);
                write_reg(CFG_YELLOW_ABOVE, 15'd50);
                write_reg(CFG_LOW_ABOVE, 15'd30);
                write_reg(CFG_SLEEP_ABOVE, 15'd10);
            end
        endcase
        cfg_write <= 1'b0;
    endtask

    // Mostly legal charge values, with some above 100 to exercise saturation.
    function automatic logic [6:0] random_percent();
        if ($urandom_range(99) < 8)
            return 7'($urandom_range(127, 101));
        return 7'($urandom_range(100, 0));
    endfunction

    // Currents cluster around the charging boundary and the extremes; the
    // rest are uniform so that every bit toggles.
    function automatic logic signed [15:0] random_current();
        int pick;
        pick = $urandom_range(99);
        if (pick < 25)
            return 16'($urandom_range(3, 0) - 2);
        if (pick < 35)
            return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        return 16'($urandom);
    endfunction

    initial begin : stimulus
        logic [6:0]         run_pct;
        logic signed [15:0] run_cur;
        rst_n           <= 1'b0;
        cfg_write       <= 1'b0;
        cfg_index       <= CFG_FADE_STEP;
        cfg_data        <= '0;
        in_valid        <= 1'b0;
        charge_percent  <= '0;
        battery_current <= '0;
        calibrate       <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed ticks on the reset thresholds (65, 25, 10, 5): every band
        // edge, both sides of the charging current, saturated charge, and the
        // crossfade ahead of sleep, solid, breathing and blink handling.
        send_tick(7'd0, 16'sd0, 1'b0);
        send_tick(7'd5, -16'sd1, 1'b0);
        send_tick(7'd6, -16'sd2, 1'b0);
        send_tick(7'd10, 16'sh7FFF, 1'b0);
        send_tick(7'd11, -16'sd1, 1'b0);
        send_tick(7'd25, 16'sd0, 1'b0);
        send_tick(7'd26, 16'sd100, 1'b0);
        send_tick(7'd65, 16'sh7FFF, 1'b0);
        send_tick(7'd66, -16'sd1, 1'b0);
        send_tick(7'd100, -16'sd2, 1'b0);
        send_tick(7'd26, 16'sh8000, 1'b0);
        send_tick(7'd11, -16'sd2, 1'b0);
        send_tick(7'd101, -16'sd100, 1'b0);
        send_tick(7'd127, 16'sd5, 1'b0);
        send_tick(7'd0, 16'sd0, 1'b1);
        send_tick(7'd3, 16'sh8000, 1'b1);
        send_tick(7'd50, -16'sd5, 1'b1);
        send_tick(7'd80, 16'sd1, 1'b1);
        send_tick(7'd8, -16'sd1, 1'b1);
        send_tick(7'd0, 16'sh5555, 1'b1);
        send_tick(7'd9, 16'shAAAA, 1'b0);
        in_valid <= 1'b0;

        // Random ticks come in runs: charge and current mostly hold for a
        // while so the fade, blink and crossfade walk far through their
        // ranges, with occasional jumps to anywhere.
        run_pct = random_percent();
        run_cur = random_current();
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            wait_drained();
            apply_setting(seg);
            if (seg == 2) begin
                in_idle_pct  = 74;
                out_idle_pct = 14;
            end
            else if (seg == 4) begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end
            for (int n = 0; n < TICKS_PER_SEGMENT; n++) begin
                if ($urandom_range(99) < 6)
                    run_pct = random_percent();
                if ($urandom_range(99) < 5)
                    run_cur = random_current();
                if ($urandom_range(99) < 10)
                    send_tick(random_percent(), random_current(), 1'($urandom_range(1)));
                else
                    send_tick(run_pct, run_cur, $urandom_range(99) < 50);
            end
            in_valid <= 1'b0;
        end

        // Let every result drain, then keep the clock running with no input
        // so a stray extra transfer would still be caught.
        wait_drained();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && levels_pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
